[hw/rtl/vsfs_pkg.sv]
// Shared types, constants and field widths for the voxel sphere field splat block.
package vsfs_pkg;

   localparam int MAX_EXTENT_DEF = 32;

   localparam int CSR_W       = 6;
   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_W-1:0] EXTENT_RESET = 6'd10;

   localparam int ACTION_W    = 2;
   localparam int VOXEL_W     = 5;
   localparam int VALUE_W     = 32;
   localparam int COORD_W     = 18;
   localparam int FRAC_W      = 8;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 40;

   // distance is Q12.8 at the default extent; d > 0.1 exactly when d >= 26 lsb
   localparam int D_MIN_DIV   = 26;
   localparam int NEAR_MUL    = 10;
   localparam int GAIN_W      = 34;
   localparam int SUM_W       = 36;
   localparam logic signed [SUM_W-1:0] Q_MAX = 36'sd2147483647;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXTENT_X = 2'd0,
      CSR_EXTENT_Y = 2'd1,
      CSR_EXTENT_Z = 2'd2
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_FILL   = 2'd2,
      ACT_SPHERE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_FILL,
      ST_MUL,
      ST_ROOT_GO,
      ST_ROOT,
      ST_DIV,
      ST_ACC,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/voxel_sphere_field_splat.sv]
// Voxel scalar field with write, read, fill and sphere splat commands.
//
//   channel  dir  ports            word
//   req      in   req_t*           action, voxel xyz, field_value, center xyz, radius
//   rsp      out  rsp_t*           read_value, saturated
//   csr      in   csr_we/index/wd  extent_x, extent_y, extent_z
//
// Write: ST_EXEC, then ST_FINISH loads the result register. Read: ST_EXEC,
// ST_RD_WAIT (in-grid only), ST_FINISH. Fill: one voxel per cycle, then ST_FINISH.
// Sphere: per voxel ST_MUL, ST_ROOT_GO and the square root (its root has half the
// squared-distance width); voxels inside the radius add the divider unless near the
// center, then write back in ST_ACC. One item is in work at a time.
// Reset is synchronous; extents return to 10, memory contents are undefined.
// A result waiting on rsp_tready holds the next item only at its final step.
module voxel_sphere_field_splat #(
   parameter int MAX_EXTENT = vsfs_pkg::MAX_EXTENT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // action[1:0], voxel_x, voxel_y, voxel_z, field_value, center_x, center_y,
   // center_z, radius, zero pad
   input  logic [vsfs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_value[31:0], saturated[32], zero pad
   output logic [vsfs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [vsfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vsfs_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int IW  = $clog2(MAX_EXTENT);
   localparam int EW  = $clog2(MAX_EXTENT + 1);
   localparam int AW  = 3 * IW;
   localparam int DW  = ((IW + 9 > vsfs_pkg::COORD_W) ? IW + 9 : vsfs_pkg::COORD_W) + 1;
   localparam int SW  = 2 * DW + 2;
   localparam int RW  = SW / 2;
   localparam int CW  = vsfs_pkg::COORD_W;
   localparam int VW  = vsfs_pkg::VALUE_W;
   localparam int GW  = vsfs_pkg::GAIN_W;

   vsfs_pkg::state_type state_ff, state_in;

   logic [vsfs_pkg::CSR_W-1:0] ext_x_ff, ext_y_ff, ext_z_ff;
   logic [EW-1:0]              ex, ey, ez;

   vsfs_pkg::action_type       act_ff;
   logic [vsfs_pkg::VOXEL_W-1:0] vx_ff, vy_ff, vz_ff;
   logic [VW-1:0]              fval_ff;
   logic signed [CW-1:0]       cx_ff, cy_ff, cz_ff;
   logic [CW-1:0]              rad_ff;
   logic [IW-1:0]              x_ff, y_ff, z_ff;
   logic [2*DW-1:0]            sqx_ff, sqy_ff, sqz_ff;
   logic [GW-1:0]              gain_ff;
   logic [VW-1:0]              res_val_ff;
   logic                       res_sat_ff;
   logic                       rsp_valid_ff;
   logic [VW-1:0]              rsp_val_ff;
   logic                       rsp_sat_ff;

   logic                       accept;
   logic                       in_grid;
   logic                       x_last, y_last, z_last, scan_last;
   logic                       advance;
   logic [AW-1:0]              item_addr, scan_addr;
   logic signed [DW-1:0]       dx, dy, dz;
   logic signed [2*DW-1:0]     px, py, pz;
   logic [SW-1:0]              sq_sum;
   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_addr;
   logic [VW-1:0]              mem_wdata, mem_rdata;
   logic                       sqrt_start, sqrt_done;
   logic [RW-1:0]              distance;
   logic                       div_start, div_done;
   logic [GW-1:0]              div_quot;
   logic                       outside_r, near_c;
   logic [GW-1:0]              near_gain;
   logic signed [vsfs_pkg::SUM_W-1:0] acc_sum;
   logic                       acc_sat;
   logic                       load_rsp;

   // effective extents: 0 acts as 1, above MAX_EXTENT clamps
   assign ex = (ext_x_ff == '0) ? EW'(1) :
               (32'(ext_x_ff) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext_x_ff);
   assign ey = (ext_y_ff == '0) ? EW'(1) :
               (32'(ext_y_ff) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext_y_ff);
   assign ez = (ext_z_ff == '0) ? EW'(1) :
               (32'(ext_z_ff) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(ext_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= vsfs_pkg::EXTENT_RESET;
         ext_y_ff <= vsfs_pkg::EXTENT_RESET;
         ext_z_ff <= vsfs_pkg::EXTENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vsfs_pkg::CSR_EXTENT_X: ext_x_ff <= csr_wdata;
            vsfs_pkg::CSR_EXTENT_Y: ext_y_ff <= csr_wdata;
            vsfs_pkg::CSR_EXTENT_Z: ext_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == vsfs_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign in_grid = (32'(vx_ff) < 32'(ex)) && (32'(vy_ff) < 32'(ey)) &&
                    (32'(vz_ff) < 32'(ez));
   assign item_addr = {IW'(vz_ff), IW'(vy_ff), IW'(vx_ff)};
   assign scan_addr = {z_ff, y_ff, x_ff};

   assign x_last    = (EW'(x_ff) + EW'(1) == ex);
   assign y_last    = (EW'(y_ff) + EW'(1) == ey);
   assign z_last    = (EW'(z_ff) + EW'(1) == ez);
   assign scan_last = x_last && y_last && z_last;

   // distance terms, Q.8 voxel position minus center
   assign dx = $signed(DW'({x_ff, 8'b0})) - DW'(cx_ff);
   assign dy = $signed(DW'({y_ff, 8'b0})) - DW'(cy_ff);
   assign dz = $signed(DW'({z_ff, 8'b0})) - DW'(cz_ff);
   assign px = dx * dx;
   assign py = dy * dy;
   assign pz = dz * dz;
   assign sq_sum = SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);

   assign outside_r = (distance >= RW'(rad_ff));
   assign near_c    = (distance < RW'(vsfs_pkg::D_MIN_DIV));
   assign near_gain = (GW'(rad_ff) * GW'(vsfs_pkg::NEAR_MUL)) << vsfs_pkg::FRAC_W;

   assign acc_sum = vsfs_pkg::SUM_W'($signed(mem_rdata)) +
                    $signed(vsfs_pkg::SUM_W'(gain_ff));
   assign acc_sat = (acc_sum > vsfs_pkg::Q_MAX);

   assign load_rsp = (state_ff == vsfs_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vsfs_pkg::ST_IDLE: begin
            if (accept) state_in = vsfs_pkg::ST_EXEC;
         end
         vsfs_pkg::ST_EXEC: begin
            case (act_ff)
               vsfs_pkg::ACT_WRITE:  state_in = vsfs_pkg::ST_FINISH;
               vsfs_pkg::ACT_READ:
                  state_in = in_grid ? vsfs_pkg::ST_RD_WAIT : vsfs_pkg::ST_FINISH;
               vsfs_pkg::ACT_FILL:   state_in = vsfs_pkg::ST_FILL;
               default:              state_in = vsfs_pkg::ST_MUL;
            endcase
         end
         vsfs_pkg::ST_RD_WAIT: state_in = vsfs_pkg::ST_FINISH;
         vsfs_pkg::ST_FILL: begin
            if (scan_last) state_in = vsfs_pkg::ST_FINISH;
         end
         vsfs_pkg::ST_MUL:     state_in = vsfs_pkg::ST_ROOT_GO;
         vsfs_pkg::ST_ROOT_GO: state_in = vsfs_pkg::ST_ROOT;
         vsfs_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               if (outside_r)
                  state_in = scan_last ? vsfs_pkg::ST_FINISH : vsfs_pkg::ST_MUL;
               else if (near_c)
                  state_in = vsfs_pkg::ST_ACC;
               else
                  state_in = vsfs_pkg::ST_DIV;
            end
         end
         vsfs_pkg::ST_DIV: begin
            if (div_done) state_in = vsfs_pkg::ST_ACC;
         end
         vsfs_pkg::ST_ACC:
            state_in = scan_last ? vsfs_pkg::ST_FINISH : vsfs_pkg::ST_MUL;
         vsfs_pkg::ST_FINISH: begin
            if (load_rsp) state_in = vsfs_pkg::ST_IDLE;
         end
         default: state_in = vsfs_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = scan_addr;
      mem_wdata  = fval_ff;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      advance    = 1'b0;
      unique case (state_ff)
         vsfs_pkg::ST_EXEC: begin
            mem_addr = item_addr;
            mem_we   = (act_ff == vsfs_pkg::ACT_WRITE) && in_grid;
            mem_re   = (act_ff == vsfs_pkg::ACT_READ) && in_grid;
         end
         vsfs_pkg::ST_FILL: begin
            mem_we  = 1'b1;
            advance = 1'b1;
         end
         vsfs_pkg::ST_MUL:     mem_re = 1'b1;
         vsfs_pkg::ST_ROOT_GO: sqrt_start = 1'b1;
         vsfs_pkg::ST_ROOT: begin
            div_start = sqrt_done && !outside_r && !near_c;
            advance   = sqrt_done && outside_r;
         end
         vsfs_pkg::ST_ACC: begin
            mem_we    = 1'b1;
            mem_wdata = acc_sat ? VW'(vsfs_pkg::Q_MAX) : acc_sum[VW-1:0];
            advance   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vsfs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= vsfs_pkg::action_type'(req_tdata[1:0]);
         vx_ff   <= req_tdata[6:2];
         vy_ff   <= req_tdata[11:7];
         vz_ff   <= req_tdata[16:12];
         fval_ff <= req_tdata[48:17];
         cx_ff   <= req_tdata[66:49];
         cy_ff   <= req_tdata[84:67];
         cz_ff   <= req_tdata[102:85];
         rad_ff  <= req_tdata[120:103];
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
      end else if (advance) begin
         x_ff <= x_last ? '0 : x_ff + IW'(1);
         if (x_last) begin
            y_ff <= y_last ? '0 : y_ff + IW'(1);
            if (y_last) z_ff <= z_ff + IW'(1);
         end
      end

      if (state_ff == vsfs_pkg::ST_MUL) begin
         sqx_ff <= $unsigned(px);
         sqy_ff <= $unsigned(py);
         sqz_ff <= $unsigned(pz);
      end

      if (state_ff == vsfs_pkg::ST_ROOT && sqrt_done)
         gain_ff <= near_gain;
      else if (state_ff == vsfs_pkg::ST_DIV && div_done)
         gain_ff <= div_quot;

      if (state_ff == vsfs_pkg::ST_EXEC) begin
         res_val_ff <= '0;
         res_sat_ff <= 1'b0;
      end else if (state_ff == vsfs_pkg::ST_RD_WAIT) begin
         res_val_ff <= mem_rdata;
      end else if (state_ff == vsfs_pkg::ST_ACC && acc_sat) begin
         res_sat_ff <= 1'b1;
      end

      if (load_rsp) begin
         rsp_val_ff <= res_val_ff;
         rsp_sat_ff <= res_sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_sat_ff, rsp_val_ff};

   vsfs_store #(.ADDR_W(AW)) u_store (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   vsfs_sqrt #(.WIDTH(SW)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sq_sum),
      .done    (sqrt_done),
      .root    (distance)
   );

   // only reached with d < radius, so d fits the radius width
   vsfs_div #(.NUM_W(GW), .DEN_W(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({rad_ff - distance[CW-1:0], 16'b0}),
      .denom (distance[CW-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

[hw/rtl/vsfs_store.sv]
// Voxel memory: one synchronous port, registered read data.
module vsfs_store #(
   parameter int ADDR_W = 15
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic                         re,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [vsfs_pkg::VALUE_W-1:0] wdata,
   output logic [vsfs_pkg::VALUE_W-1:0] rdata
);

   logic [vsfs_pkg::VALUE_W-1:0] mem [0:(1<<ADDR_W)-1];
   logic [vsfs_pkg::VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/vsfs_sqrt.sv]
// Iterative integer square root, one root bit per cycle.
module vsfs_sqrt #(
   parameter int WIDTH = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   operand,
   output logic               done,
   output logic [WIDTH/2-1:0] root
);

   localparam int RW    = WIDTH / 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic [WIDTH-1:0] op_ff;
   logic [RW+1:0]    rem_ff;
   logic [RW-1:0]    root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RW+1:0]    rem_sh;
   logic [RW+1:0]    trial;
   logic             fits;

   assign rem_sh = {rem_ff[RW-1:0], op_ff[WIDTH-1:WIDTH-2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(RW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         op_ff   <= {op_ff[WIDTH-3:0], 2'b00};
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[RW-2:0], fits};
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/vsfs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module vsfs_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic             fits;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[hw/rtl/vsfs_check.sv]
// Port-level checks for the voxel sphere field splat block, bound to the top level.
module vsfs_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [vsfs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a held result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // no second command is taken in the cycle after one is taken
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[vsfs_pkg::RSP_TDATA_W-1:33] == '0)
      else $error("rsp pad bits set");

endmodule

bind voxel_sphere_field_splat vsfs_check u_vsfs_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
